### hdl/heater_power_controller_top_defines.svh
// Assertion macros shared by the heater power controller modules.
`ifndef HEATER_POWER_CONTROLLER_TOP_DEFINES_SVH
`define HEATER_POWER_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define HPC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check that cons holds in the cycle after ante.
`define HPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HPC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define HPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### hdl/hpc_pkg.sv
// Types, constants and register indexes of the heater power controller.
`default_nettype none

package hpc_pkg;

   localparam int TIME_BITS = 32;

   localparam logic [7:0]  FULL_POWER     = 8'd255;
   localparam logic [7:0]  MIN_POWER      = 8'd30;
   localparam logic [6:0]  PERCENT_MAX    = 7'd100;
   // 0.96 in 16-bit fixed point, rounded up so that p*96/100 truncates exactly
   localparam logic [15:0] ADV_SCALE      = 16'd62915;
   localparam logic [3:0]  SEND_DELTA     = 4'd10;
   localparam logic [TIME_BITS-1:0] SEND_PERIOD_MS = TIME_BITS'(10000);
   localparam logic [9:0]  MS_PER_S       = 10'd1000;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 17;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE_ADVANCED     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SETPOINT_TENTHS   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HYSTERESIS_TENTHS = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAIT_SECONDS      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEAT_SECONDS      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POWER_PERCENT     = 3'd5;

   typedef struct packed {
      logic        mode_advanced;
      logic [8:0]  setpoint_tenths;
      logic [6:0]  hysteresis_tenths;
      logic [16:0] wait_seconds;
      logic [16:0] heat_seconds;
      logic [6:0]  power_percent;
   } cfg_type;

   typedef struct packed {
      logic signed [10:0]   temperature_tenths;
      logic                 reading_valid;
      logic [TIME_BITS-1:0] now_ms;
      logic                 restart_timer;
      logic                 transmit_allowed;
   } req_type;

   typedef struct packed {
      logic [7:0] power;
      logic       send_packet;
      logic       heating_latched;
      logic       heating_phase;
   } rsp_type;

endpackage

`default_nettype wire

### hdl/hpc_ctrl.sv
// Controller state and the per-sample power, phase and send decision.
`default_nettype none
`include "heater_power_controller_top_defines.svh"

module hpc_ctrl
   import hpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  cfg_type cfg,
   input  req_type item,
   output rsp_type result
);

   logic signed [10:0]   last_temp_ff, last_temp_in;
   logic                 latch_ff, latch_in;
   logic                 started_ff, started_in;
   logic                 heating_ff, heating_in;
   logic [TIME_BITS-1:0] phase_start_ff, phase_start_in;
   logic [7:0]           last_sent_ff, last_sent_in;
   logic [TIME_BITS-1:0] last_send_ms_ff, last_send_ms_in;

   logic signed [12:0]   temp_s;
   logic signed [12:0]   setpoint_s;
   logic signed [12:0]   on_level_s;
   logic signed [12:0]   error_s;
   logic [7:0]           clamped_power;
   logic [6:0]           percent_sat;
   logic [22:0]          percent_product;
   logic [7:0]           adv_power;
   logic [26:0]          wait_ms;
   logic [26:0]          heat_ms;
   logic                 phase_heating;
   logic [TIME_BITS-1:0] phase_start;
   logic [TIME_BITS-1:0] elapsed;
   logic [7:0]           power;
   logic signed [8:0]    power_delta;
   logic [8:0]           power_delta_abs;
   logic [TIME_BITS-1:0] since_send;
   logic                 send;

   // temperature path of simple mode
   always_comb begin
      last_temp_in  = item.reading_valid ? item.temperature_tenths : last_temp_ff;
      temp_s        = {{2{last_temp_in[10]}}, last_temp_in};
      setpoint_s    = $signed({4'b0, cfg.setpoint_tenths});
      on_level_s    = setpoint_s - $signed({6'b0, cfg.hysteresis_tenths});
      error_s       = setpoint_s - temp_s;
      if (error_s > $signed({5'b0, FULL_POWER})) begin
         clamped_power = FULL_POWER;
      end else if (error_s < $signed({5'b0, MIN_POWER})) begin
         clamped_power = MIN_POWER;
      end else begin
         clamped_power = error_s[7:0];
      end
   end

   // interval timer arithmetic of advanced mode
   always_comb begin
      percent_sat     = (cfg.power_percent > PERCENT_MAX) ? PERCENT_MAX : cfg.power_percent;
      percent_product = 23'(percent_sat) * 23'(ADV_SCALE);
      adv_power       = MIN_POWER + {1'b0, percent_product[22:16]};
      wait_ms         = 27'(cfg.wait_seconds) * 27'(MS_PER_S);
      heat_ms         = 27'(cfg.heat_seconds) * 27'(MS_PER_S);
      // start or restart the cycle in the wait phase at this sample
      if (!started_ff || item.restart_timer) begin
         phase_heating = 1'b0;
         phase_start   = item.now_ms;
      end else begin
         phase_heating = heating_ff;
         phase_start   = phase_start_ff;
      end
      elapsed = item.now_ms - phase_start;
   end

   always_comb begin
      latch_in       = latch_ff;
      started_in     = started_ff;
      heating_in     = heating_ff;
      phase_start_in = phase_start_ff;
      power          = 8'd0;
      if (!cfg.mode_advanced) begin
         if (latch_ff) begin
            if (temp_s >= setpoint_s) begin
               latch_in = 1'b0;
            end else begin
               power = clamped_power;
            end
         end else if (temp_s <= on_level_s) begin
            latch_in = 1'b1;
            power    = FULL_POWER;
         end
      end else begin
         started_in     = 1'b1;
         heating_in     = phase_heating;
         phase_start_in = phase_start;
         if (!phase_heating) begin
            if (elapsed >= TIME_BITS'(wait_ms)) begin
               heating_in     = 1'b1;
               phase_start_in = item.now_ms;
            end
         end else if (elapsed >= TIME_BITS'(heat_ms)) begin
            heating_in     = 1'b0;
            phase_start_in = item.now_ms;
         end else begin
            power = adv_power;
         end
      end
   end

   // send decision
   always_comb begin
      power_delta     = $signed({1'b0, power}) - $signed({1'b0, last_sent_ff});
      power_delta_abs = power_delta[8] ? 9'(-power_delta) : 9'(power_delta);
      since_send      = item.now_ms - last_send_ms_ff;
      send            = item.transmit_allowed &&
                        ((power_delta_abs > 9'(SEND_DELTA)) || (since_send > SEND_PERIOD_MS));
      last_sent_in    = send ? power : last_sent_ff;
      last_send_ms_in = send ? item.now_ms : last_send_ms_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_temp_ff    <= '0;
         latch_ff        <= 1'b0;
         started_ff      <= 1'b0;
         heating_ff      <= 1'b0;
         phase_start_ff  <= '0;
         last_sent_ff    <= '0;
         last_send_ms_ff <= '0;
      end else if (step) begin
         last_temp_ff    <= last_temp_in;
         latch_ff        <= latch_in;
         started_ff      <= started_in;
         heating_ff      <= heating_in;
         phase_start_ff  <= phase_start_in;
         last_sent_ff    <= last_sent_in;
         last_send_ms_ff <= last_send_ms_in;
      end
   end

   assign result.power           = power;
   assign result.send_packet     = send;
   assign result.heating_latched = latch_in;
   assign result.heating_phase   = heating_in;

   `HPC_ASSERT_NEXT(a_send_records_power, clock, reset, step && send,
      last_sent_ff == $past(power), "sent power not recorded")
   `HPC_ASSERT_NOW(a_simple_power_range, clock, reset, step && !cfg.mode_advanced,
      (latch_in ? (power >= MIN_POWER) : (power == 8'd0)), "simple mode power out of band")

endmodule

`default_nettype wire

### hdl/heater_power_controller_top.sv
// Top level of the heater power controller: handshakes, registers and stages.
`default_nettype none
`include "heater_power_controller_top_defines.svh"

// Heater power controller. Each req beat carries one temperature sample with
// its time stamp; each sample yields exactly one rsp beat with the heater
// power, the send flag and the two mode states. In simple mode a hysteresis
// latch drives full power at or below setpoint minus hysteresis, then follows
// the error clamped to 30..255 until the setpoint is reached. In advanced
// mode a wait/heat interval timer runs off the sample time stamps. Rate: one
// sample per clock cycle while the receiver does not stall; each sample
// passes the sample register, then the result register, on its way to its
// rsp beat; the controller updates its state as the sample advances. The
// csr port writes one register per cycle with no wait; write it only while
// no sample is in flight. Synchronous active-high reset restores register
// defaults (simple mode, setpoint 22.0, hysteresis 0.5), clears all but payload.
module heater_power_controller_top
   import hpc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // sample channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [10:0]        req_temperature_tenths,
   input  logic                      req_reading_valid,
   input  logic [TIME_BITS-1:0]      req_now_ms,
   input  logic                      req_restart_timer,
   input  logic                      req_transmit_allowed,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_power,
   output logic                      rsp_send_packet,
   output logic                      rsp_heating_latched,
   output logic                      rsp_heating_phase,
   // register write port
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   cfg_type cfg_ff, cfg_in;

   logic    sample_valid_ff, sample_valid_in;
   req_type sample_ff, sample_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic    req_take;
   logic    advance;
   rsp_type result;

   // Register file: take one write per cycle, drop writes to unknown indexes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MODE_ADVANCED:     cfg_in.mode_advanced     = csr_write_data[0];
            CSR_SETPOINT_TENTHS:   cfg_in.setpoint_tenths   = csr_write_data[8:0];
            CSR_HYSTERESIS_TENTHS: cfg_in.hysteresis_tenths = csr_write_data[6:0];
            CSR_WAIT_SECONDS:      cfg_in.wait_seconds      = csr_write_data[16:0];
            CSR_HEAT_SECONDS:      cfg_in.heat_seconds      = csr_write_data[16:0];
            CSR_POWER_PERCENT:     cfg_in.power_percent     = csr_write_data[6:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   // The sample stage advances whenever the result register is empty or is
   // being emptied this cycle, so a waiting result never blocks the stage
   // behind it by more than the single beat held in the result register.
   assign advance   = sample_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = sample_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      sample_in.temperature_tenths = req_temperature_tenths;
      sample_in.reading_valid      = req_reading_valid;
      sample_in.now_ms             = req_now_ms;
      sample_in.restart_timer      = req_restart_timer;
      sample_in.transmit_allowed   = req_transmit_allowed;

      // hold the sample stage while the result side is blocked
      if (req_take) begin
         sample_valid_in = 1'b1;
      end else if (advance) begin
         sample_valid_in = 1'b0;
      end else begin
         sample_valid_in = sample_valid_ff;
      end

      // load the result register on advance, drop it once the beat is taken
      rsp_in = result;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Controller: state update happens on the cycle the sample advances.
   hpc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cfg    (cfg_ff),
      .item   (sample_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode_advanced     <= 1'b0;
         cfg_ff.setpoint_tenths   <= 9'd220;
         cfg_ff.hysteresis_tenths <= 7'd5;
         cfg_ff.wait_seconds      <= '0;
         cfg_ff.heat_seconds      <= '0;
         cfg_ff.power_percent     <= '0;
         sample_valid_ff          <= 1'b0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff          <= cfg_in;
         sample_valid_ff <= sample_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= sample_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_power           = rsp_ff.power;
   assign rsp_send_packet     = rsp_ff.send_packet;
   assign rsp_heating_latched = rsp_ff.heating_latched;
   assign rsp_heating_phase   = rsp_ff.heating_phase;

   `HPC_ASSERT_NEXT(a_take_fills_stage, clock, reset, req_take,
      sample_valid_ff, "accepted sample missing from sample stage")
   `HPC_ASSERT_NOW(a_power_needs_heating, clock, reset,
      rsp_valid_ff && (rsp_ff.power != 8'd0),
      rsp_ff.heating_latched || rsp_ff.heating_phase, "power without heating state")

endmodule

`default_nettype wire

### tb/hpc_drive_checker.sv
// Checker for the heater power controller: tracks register writes, predicts each beat, compares.
`timescale 1ns / 1ps

module hpc_drive_checker
   import hpc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic signed [10:0]        req_temperature_tenths,
   input  logic                      req_reading_valid,
   input  logic [TIME_BITS-1:0]      req_now_ms,
   input  logic                      req_restart_timer,
   input  logic                      req_transmit_allowed,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [7:0]                rsp_power,
   input  logic                      rsp_send_packet,
   input  logic                      rsp_heating_latched,
   input  logic                      rsp_heating_phase,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   output int                        mismatches,
   output int                        backlog
);

   localparam int unsigned ADV_SPAN = 96;

   cfg_type               cfg;
   logic signed [10:0]    held_temp;
   logic                  latch_on;
   logic                  cycle_running;
   logic                  cycle_heat;
   logic [TIME_BITS-1:0]  phase_from_ms;
   logic [7:0]            sent_power;
   logic [TIME_BITS-1:0]  sent_at_ms;

   req_type reading_beat;
   rsp_type drive_beat;
   rsp_type due;
   rsp_type drive_queue [$];

   assign reading_beat = {req_temperature_tenths, req_reading_valid, req_now_ms,
                          req_restart_timer, req_transmit_allowed};
   assign drive_beat   = {rsp_power, rsp_send_packet, rsp_heating_latched, rsp_heating_phase};

   // Advance the controller state by one reading and return the drive it yields.
   function automatic rsp_type compute_drive(input req_type s);
      rsp_type              r;
      int                   sp;
      int                   t;
      int                   err;
      int                   diff;
      int unsigned          pct;
      longint unsigned      wait_ms;
      longint unsigned      heat_ms;
      logic [TIME_BITS-1:0] elapsed;
      logic [TIME_BITS-1:0] since_send;
      r = '0;
      if (s.reading_valid)
         held_temp = s.temperature_tenths;
      if (!cfg.mode_advanced) begin
         sp = int'(cfg.setpoint_tenths);
         t  = int'(held_temp);
         if (latch_on) begin
            if (t >= sp) begin
               latch_on = 1'b0;
            end else begin
               err = sp - t;
               if (err > int'(FULL_POWER)) err = int'(FULL_POWER);
               if (err < int'(MIN_POWER)) err = int'(MIN_POWER);
               r.power = err[7:0];
            end
         end else if (t <= sp - int'(cfg.hysteresis_tenths)) begin
            latch_on = 1'b1;
            r.power  = FULL_POWER;
         end
      end else begin
         wait_ms = longint'(cfg.wait_seconds) * MS_PER_S;
         heat_ms = longint'(cfg.heat_seconds) * MS_PER_S;
         if (!cycle_running || s.restart_timer) begin
            cycle_running = 1'b1;
            cycle_heat    = 1'b0;
            phase_from_ms = s.now_ms;
         end
         elapsed = s.now_ms - phase_from_ms;
         if (!cycle_heat) begin
            // the reading that ends the wait still drives nothing
            if (elapsed >= wait_ms) begin
               cycle_heat    = 1'b1;
               phase_from_ms = s.now_ms;
            end
         end else begin
            if (elapsed >= heat_ms) begin
               cycle_heat    = 1'b0;
               phase_from_ms = s.now_ms;
            end
            if (cycle_heat) begin
               pct     = (cfg.power_percent > PERCENT_MAX) ? PERCENT_MAX : cfg.power_percent;
               r.power = MIN_POWER + 8'(pct * ADV_SPAN / int'(PERCENT_MAX));
            end
         end
      end
      if (s.transmit_allowed) begin
         diff = int'(r.power) - int'(sent_power);
         if (diff < 0) diff = -diff;
         since_send = s.now_ms - sent_at_ms;
         if (diff > int'(SEND_DELTA) || since_send > SEND_PERIOD_MS) begin
            r.send_packet = 1'b1;
            sent_power    = r.power;
            sent_at_ms    = s.now_ms;
         end
      end
      r.heating_latched = latch_on;
      r.heating_phase   = cycle_heat;
      return r;
   endfunction

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg           = '{mode_advanced: 1'b0, setpoint_tenths: 9'd220,
                           hysteresis_tenths: 7'd5, default: '0};
         held_temp     = '0;
         latch_on      = 1'b0;
         cycle_running = 1'b0;
         cycle_heat    = 1'b0;
         phase_from_ms = '0;
         sent_power    = '0;
         sent_at_ms    = '0;
         drive_queue.delete();
         mismatches    = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MODE_ADVANCED:     cfg.mode_advanced     = csr_write_data[0];
               CSR_SETPOINT_TENTHS:   cfg.setpoint_tenths   = csr_write_data[8:0];
               CSR_HYSTERESIS_TENTHS: cfg.hysteresis_tenths = csr_write_data[6:0];
               CSR_WAIT_SECONDS:      cfg.wait_seconds      = csr_write_data[16:0];
               CSR_HEAT_SECONDS:      cfg.heat_seconds      = csr_write_data[16:0];
               CSR_POWER_PERCENT:     cfg.power_percent     = csr_write_data[6:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            drive_queue.push_back(compute_drive(reading_beat));
         if (rsp_valid && !rsp_stall) begin
            if (drive_queue.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, got power %0d",
                        $time, drive_beat.power);
               mismatches++;
            end else begin
               due = drive_queue.pop_front();
               check_field("power", due.power, drive_beat.power);
               check_field("send_packet", due.send_packet, drive_beat.send_packet);
               check_field("heating_latched", due.heating_latched, drive_beat.heating_latched);
               check_field("heating_phase", due.heating_phase, drive_beat.heating_phase);
            end
         end
      end
      backlog <= drive_queue.size();
   end

endmodule

### tb/tb_heater_power_controller_top.sv
// Testbench top for the heater power controller: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_heater_power_controller_top
   import hpc_pkg::*;
();

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [10:0]        req_temperature_tenths = '0;
   logic                      req_reading_valid = 1'b0;
   logic [TIME_BITS-1:0]      req_now_ms = '0;
   logic                      req_restart_timer = 1'b0;
   logic                      req_transmit_allowed = 1'b0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [7:0]                rsp_power;
   logic                      rsp_send_packet;
   logic                      rsp_heating_latched;
   logic                      rsp_heating_phase;

   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_write_data = '0;

   int                        mismatches;
   int                        backlog;

   // steady: no sender gaps and no receiver stalls; hold_kick: start a long receiver hold-off
   bit                        steady = 1'b0;
   bit                        hold_kick = 1'b0;
   int                        hold_left = 0;

   // stimulus view of the live settings and of wall-clock time
   int                        cur_setpoint = 220;
   int                        cur_hyst = 5;
   logic [TIME_BITS-1:0]      clock_ms = '0;

   always #2 clock = ~clock;

   heater_power_controller_top uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_temperature_tenths (req_temperature_tenths),
      .req_reading_valid      (req_reading_valid),
      .req_now_ms             (req_now_ms),
      .req_restart_timer      (req_restart_timer),
      .req_transmit_allowed   (req_transmit_allowed),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_power              (rsp_power),
      .rsp_send_packet        (rsp_send_packet),
      .rsp_heating_latched    (rsp_heating_latched),
      .rsp_heating_phase      (rsp_heating_phase),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data)
   );

   hpc_drive_checker u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_temperature_tenths (req_temperature_tenths),
      .req_reading_valid      (req_reading_valid),
      .req_now_ms             (req_now_ms),
      .req_restart_timer      (req_restart_timer),
      .req_transmit_allowed   (req_transmit_allowed),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_power              (rsp_power),
      .rsp_send_packet        (rsp_send_packet),
      .rsp_heating_latched    (rsp_heating_latched),
      .rsp_heating_phase      (rsp_heating_phase),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .mismatches             (mismatches),
      .backlog                (backlog)
   );

   // Receiver: stall about a quarter of the time, hold off for a long stretch on request,
   // and stay open throughout a steady phase.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_kick) begin
            hold_kick = 1'b0;
            hold_left = 60;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 24);
         end
      end
   end

   // Offer one reading beat, with random idle cycles in front, and hold it until taken.
   task automatic offer_reading(input logic signed [10:0] temp, input logic valid_rd,
                                input logic [TIME_BITS-1:0] now, input logic restart,
                                input logic tx_ok);
      while (!steady && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_temperature_tenths <= temp;
      req_reading_valid      <= valid_rd;
      req_now_ms             <= now;
      req_restart_timer      <= restart;
      req_transmit_allowed   <= tx_ok;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop the request and wait until every predicted drive beat has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                          input logic [CSR_DATA_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   // Quiesce, then rewrite every register.
   task automatic retune(input int mode, input int sp, input int hy, input int wt,
                         input int ht, input int pc);
      drain();
      set_reg(CSR_MODE_ADVANCED, CSR_DATA_BITS'(mode));
      set_reg(CSR_SETPOINT_TENTHS, CSR_DATA_BITS'(sp));
      set_reg(CSR_HYSTERESIS_TENTHS, CSR_DATA_BITS'(hy));
      set_reg(CSR_WAIT_SECONDS, CSR_DATA_BITS'(wt));
      set_reg(CSR_HEAT_SECONDS, CSR_DATA_BITS'(ht));
      set_reg(CSR_POWER_PERCENT, CSR_DATA_BITS'(pc));
      csr_write_enable <= 1'b0;
      cur_setpoint = sp;
      cur_hyst     = hy;
   endtask

   // Mostly a temperature walk across the hysteresis band with time moving forward;
   // the rest is noise with arbitrary temperatures and time stamps.
   task automatic random_burst(input int count, input bit pressure);
      int                   temp;
      logic [TIME_BITS-1:0] now;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 12) begin
            temp     = $urandom;
            now      = $urandom;
            clock_ms = now;
         end else begin
            temp     = cur_setpoint - cur_hyst - 20 + $urandom_range(0, cur_hyst + 40);
            now      = clock_ms;
            clock_ms = clock_ms + ($urandom_range(99) < 5 ? $urandom_range(8000, 15000)
                                                          : $urandom_range(0, 2500));
         end
         if (pressure && i == 20)
            hold_kick = 1'b1;
         offer_reading(11'(temp), $urandom_range(99) < 85, now, $urandom_range(99) < 5,
                       $urandom_range(99) < 80);
      end
   endtask

   function automatic int pick_duration();
      return ($urandom_range(7) == 0) ? 131071 : $urandom_range(0, 4);
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Simple mode on reset settings: latch on, error tracking, clamp at both ends,
      // latch off at the setpoint, an invalid reading keeping the old temperature.
      offer_reading(11'sd0, 1'b1, 32'd0, 1'b0, 1'b1);
      offer_reading(11'sd300, 1'b0, 32'd100, 1'b0, 1'b1);
      offer_reading(11'sd215, 1'b1, 32'd200, 1'b0, 1'b1);
      offer_reading(11'sd219, 1'b1, 32'd300, 1'b0, 1'b1);
      offer_reading(11'sd220, 1'b1, 32'd400, 1'b0, 1'b1);
      offer_reading(11'sd216, 1'b1, 32'd500, 1'b0, 1'b1);
      offer_reading(11'sd215, 1'b1, 32'd10600, 1'b0, 1'b1);
      offer_reading(-11'sd1024, 1'b1, 32'd20700, 1'b0, 1'b1);
      offer_reading(11'sd1023, 1'b1, 32'd20800, 1'b0, 1'b1);
      offer_reading(-11'sd400, 1'b1, 32'd20900, 1'b0, 1'b0);

      // Widest setpoint and band.
      retune(0, 511, 127, 0, 0, 0);
      offer_reading(11'sd384, 1'b1, 32'd21000, 1'b0, 1'b1);
      offer_reading(11'sd1023, 1'b1, 32'd21100, 1'b0, 1'b1);
      offer_reading(11'sd384, 1'b1, 32'd21200, 1'b0, 1'b1);

      // Zero setpoint and zero band.
      retune(0, 0, 0, 0, 0, 0);
      offer_reading(11'sd0, 1'b1, 32'd21300, 1'b0, 1'b1);
      offer_reading(-11'sd1, 1'b1, 32'd21400, 1'b0, 1'b1);
      offer_reading(-11'sd1, 1'b1, 32'd21500, 1'b0, 1'b1);

      // Timer with zero durations across the time stamp wrap; percent above range.
      retune(1, 220, 5, 0, 0, 127);
      offer_reading(11'sd100, 1'b1, 32'hFFFF_FFF0, 1'b0, 1'b1);
      offer_reading(11'sd100, 1'b1, 32'h0000_0010, 1'b0, 1'b1);
      offer_reading(11'sd100, 1'b1, 32'h0000_0020, 1'b0, 1'b1);

      // Restart, end of wait on the exact boundary, longest heat phase.
      retune(1, 220, 5, 1, 131071, 100);
      offer_reading(11'sd100, 1'b1, 32'd5000, 1'b1, 1'b1);
      offer_reading(11'sd100, 1'b1, 32'd5999, 1'b0, 1'b1);
      offer_reading(11'sd100, 1'b1, 32'd6000, 1'b0, 1'b1);
      offer_reading(11'sd100, 1'b0, 32'd7000, 1'b0, 1'b1);
      offer_reading(11'sd100, 1'b1, 32'd7100, 1'b1, 1'b0);

      // Random phases, alternating the mode so the held state of the other mode
      // carries over. One phase runs with no idling; one has a long receiver hold-off.
      clock_ms = 32'hFFFF_0000;
      for (int p = 0; p < 12; p++) begin
         retune(p % 2,
                ($urandom_range(5) == 0) ? ($urandom_range(1) ? 511 : 0)
                                         : $urandom_range(100, 350),
                ($urandom_range(7) == 0) ? 127 : $urandom_range(0, 100),
                pick_duration(), pick_duration(), $urandom_range(0, 127));
         steady = (p == 7);
         random_burst(150, p == 4);
         steady = 1'b0;
      end

      drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && backlog == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog: a correct run ends long before this.
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
